[design/tsseq_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tsseq_pkg: shared types and codes of the timed step sequencer
// Command, status and timeout action codes, the packed request and response
// layouts and the layout of one stored step entry.
// -----------------------------------------------------------------------------
package tsseq_pkg;

   // Table size and field widths
   localparam int DEF_MAX_STEPS = 16;
   localparam int SLOT_SPAN     = 16;   // entries a 4-bit slot can address
   localparam int INDEX_W       = 5;
   localparam int CMD_W         = 3;
   localparam int STATUS_W      = 3;
   localparam int TIME_W        = 32;
   localparam int TICK_W        = 16;
   localparam int RETRY_W       = 8;
   localparam int ID_W          = 15;
   localparam int CUR_ID_W      = 16;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ABORT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;

   // Mission status codes
   localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PAUSED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_COMPLETED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ABORTED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FAILED    = 3'd5;

   // Timeout actions (the unused code behaves as abort)
   localparam logic [1:0] ACT_ABORT   = 2'd0;
   localparam logic [1:0] ACT_PROCEED = 2'd1;
   localparam logic [1:0] ACT_RETRY   = 2'd2;

   // No current step
   localparam logic [CUR_ID_W-1:0] ID_NONE = 16'hFFFF;

   // Request payload, first field in the low bits (112 bits)
   typedef struct packed {
      logic                completion_met;
      logic [TICK_W-1:0]   tick_ms;
      logic [RETRY_W-1:0]  retry_limit;
      logic [1:0]          timeout_action;
      logic [TIME_W-1:0]   timeout_ms;
      logic [TIME_W-1:0]   duration_ms;
      logic                completion_mode;
      logic                step_enabled;
      logic [ID_W-1:0]     step_id;
      logic [3:0]          step_slot;
   } req_data_type;

   // Response payload, first field in the low bits (97 bits + 7 pad)
   typedef struct packed {
      logic [6:0]          pad;
      logic                evaluator_reset;
      logic [TIME_W-1:0]   total_time_ms;
      logic [TIME_W-1:0]   step_time_ms;
      logic [RETRY_W-1:0]  retries_used;
      logic [CUR_ID_W-1:0] current_id;
      logic [INDEX_W-1:0]  current_index;
      logic [STATUS_W-1:0] status;
   } rsp_data_type;

   // One step table entry
   typedef struct packed {
      logic [RETRY_W-1:0]  retry_limit;
      logic [1:0]          timeout_action;
      logic                completion_mode;
      logic                step_enabled;
      logic [ID_W-1:0]     step_id;
      logic [TIME_W-1:0]   timeout_ms;
      logic [TIME_W-1:0]   duration_ms;
   } step_entry_type;

endpackage

[design/timed_step_sequencer.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// timed_step_sequencer: mission step sequencer
// Every request (load step, start, pause, resume, abort, tick) returns one
// response with the mission state after that request. Requests are taken one
// per cycle; each passes an input register, one stage of logic and a response
// register before its response is presented.
// Throughput is one request per cycle and drops only when rsp_tready is low.
// The step table holds min(MAX_STEPS, 16) entries in flip-flops; an entry
// must be loaded before the mission reaches it. The user must write step_count
// on the csr port only while no request is in flight; this is not enforced.
// -----------------------------------------------------------------------------
module timed_step_sequencer
   import tsseq_pkg::*;
#(
   parameter int MAX_STEPS = DEF_MAX_STEPS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   // tuser: command[2:0]
   input  logic [CMD_W-1:0]    req_tuser,
   // tdata: step_slot[3:0], step_id[18:4], step_enabled[19], completion_mode[20],
   //        duration_ms[52:21], timeout_ms[84:53], timeout_action[86:85],
   //        retry_limit[94:87], tick_ms[110:95], completion_met[111]
   input  logic [111:0]        req_tdata,
   // response channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // tdata: status[2:0], current_index[7:3], current_id[23:8],
   //        retries_used[31:24], step_time_ms[63:32], total_time_ms[95:64],
   //        evaluator_reset[96], zero pad[103:97]
   output logic [103:0]        rsp_tdata,
   // step_count register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [INDEX_W-1:0]  csr_data
);

   // Table depth: only 16 slots are addressable by a load
   localparam int TBL_DEPTH = (MAX_STEPS < SLOT_SPAN) ? MAX_STEPS : SLOT_SPAN;
   localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   localparam int CNT_CAP   = (MAX_STEPS < 31) ? MAX_STEPS : 31;
   localparam logic [INDEX_W-1:0] TBL_DEPTH_V = INDEX_W'(TBL_DEPTH);
   localparam logic [INDEX_W-1:0] CNT_CAP_V   = INDEX_W'(CNT_CAP);

   // Pipeline control
   logic                 in_valid_ff;
   logic [CMD_W-1:0]     in_cmd_ff;
   req_data_type         in_data_ff;
   logic                 rsp_valid_ff;
   rsp_data_type         rsp_data_ff;
   logic                 advance;
   logic                 proc;

   // Mission state
   logic [INDEX_W-1:0]   step_count_ff;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [INDEX_W-1:0]   index_ff, index_in;
   logic [TIME_W-1:0]    step_ms_ff, step_ms_in;
   logic [TIME_W-1:0]    total_ms_ff, total_ms_in;
   logic [RETRY_W-1:0]   retry_ff, retry_in;
   step_entry_type       cur_ff, cur_in;   // copy of the entry at index_ff
   step_entry_type       tbl_mem [TBL_DEPTH];

   // Next-state helpers
   logic [INDEX_W-1:0]   eff_count;
   logic [TIME_W:0]      step_sum_w, total_sum_w;
   logic [TIME_W-1:0]    step_sum, total_sum;
   logic [INDEX_W-1:0]   next_idx;
   logic                 take_next;
   logic                 ev_reset;
   logic                 step_done;
   logic                 slot_ok;
   logic                 load_hit;
   step_entry_type       load_entry;
   step_entry_type       tbl_rd;
   logic [CUR_ID_W-1:0]  cur_id;

   // Handshakes
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign proc       = in_valid_ff && advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_data_ff <= req_data_type'(req_tdata);
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         step_count_ff <= csr_data;
      end
   end

   // Effective count, saturating timers, load entry
   always_comb begin
      eff_count   = (step_count_ff > CNT_CAP_V) ? CNT_CAP_V : step_count_ff;
      step_sum_w  = {1'b0, step_ms_ff} + {{(TIME_W + 1 - TICK_W){1'b0}}, in_data_ff.tick_ms};
      total_sum_w = {1'b0, total_ms_ff} + {{(TIME_W + 1 - TICK_W){1'b0}}, in_data_ff.tick_ms};
      step_sum    = step_sum_w[TIME_W] ? '1 : step_sum_w[TIME_W-1:0];
      total_sum   = total_sum_w[TIME_W] ? '1 : total_sum_w[TIME_W-1:0];
      next_idx    = index_ff + 1'b1;
      step_done   = cur_ff.completion_mode ? in_data_ff.completion_met
                                           : (step_sum >= cur_ff.duration_ms);
      slot_ok     = {1'b0, in_data_ff.step_slot} < TBL_DEPTH_V;
      load_entry.retry_limit     = in_data_ff.retry_limit;
      load_entry.timeout_action  = in_data_ff.timeout_action;
      load_entry.completion_mode = in_data_ff.completion_mode;
      load_entry.step_enabled    = in_data_ff.step_enabled;
      load_entry.step_id         = in_data_ff.step_id;
      load_entry.timeout_ms      = in_data_ff.timeout_ms;
      load_entry.duration_ms     = in_data_ff.duration_ms;
   end

   // Command decode and step rules
   always_comb begin
      status_in   = status_ff;
      index_in    = index_ff;
      step_ms_in  = step_ms_ff;
      total_ms_in = total_ms_ff;
      retry_in    = retry_ff;
      ev_reset    = 1'b0;
      take_next   = 1'b0;
      unique case (in_cmd_ff)
         CMD_LOAD: begin
            status_in = status_ff;
         end
         CMD_START: begin
            if (eff_count == '0) begin
               status_in = ST_FAILED;
            end else begin
               status_in   = ST_RUNNING;
               index_in    = '0;
               step_ms_in  = '0;
               total_ms_in = '0;
               retry_in    = '0;
               ev_reset    = 1'b1;
            end
         end
         CMD_PAUSE: begin
            if (status_ff == ST_RUNNING) status_in = ST_PAUSED;
         end
         CMD_RESUME: begin
            if (status_ff == ST_PAUSED) status_in = ST_RUNNING;
         end
         CMD_ABORT: begin
            status_in = ST_ABORTED;
         end
         CMD_TICK: begin
            if (status_ff == ST_RUNNING && eff_count != '0) begin
               total_ms_in = total_sum;
               step_ms_in  = step_sum;
               if (index_ff >= eff_count) begin
                  // count lowered under a running mission
                  status_in = ST_COMPLETED;
               end else if (!cur_ff.step_enabled) begin
                  take_next = 1'b1;
               end else if (step_sum > cur_ff.timeout_ms) begin
                  if (cur_ff.timeout_action == ACT_PROCEED) begin
                     take_next = 1'b1;
                  end else if (cur_ff.timeout_action == ACT_RETRY &&
                               retry_ff < cur_ff.retry_limit) begin
                     retry_in   = retry_ff + 1'b1;
                     step_ms_in = '0;
                     ev_reset   = 1'b1;
                  end else begin
                     status_in = ST_ABORTED;
                  end
               end else if (step_done) begin
                  take_next = 1'b1;
               end
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase

      // Advance to the following step, or finish the mission
      if (take_next) begin
         index_in = next_idx;
         if (next_idx >= eff_count) begin
            status_in = ST_COMPLETED;
         end else begin
            step_ms_in = '0;
            retry_in   = '0;
            ev_reset   = 1'b1;
         end
      end
   end

   // Entry of the new current step, with bypass of a load in this request
   always_comb begin
      tbl_rd   = (index_in < TBL_DEPTH_V) ? tbl_mem[index_in[TBL_AW-1:0]] : '0;
      load_hit = (in_cmd_ff == CMD_LOAD) && slot_ok &&
                 ({1'b0, in_data_ff.step_slot} == index_in);
      cur_in   = load_hit ? load_entry : tbl_rd;
      cur_id   = (index_in < eff_count) ? {1'b0, cur_in.step_id} : ID_NONE;
   end

   // Step table
   always_ff @(posedge clock) begin
      if (proc && in_cmd_ff == CMD_LOAD && slot_ok) begin
         tbl_mem[in_data_ff.step_slot[TBL_AW-1:0]] <= load_entry;
      end
   end

   // Mission state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= ST_IDLE;
         index_ff    <= '0;
         step_ms_ff  <= '0;
         total_ms_ff <= '0;
         retry_ff    <= '0;
      end else if (proc) begin
         status_ff   <= status_in;
         index_ff    <= index_in;
         step_ms_ff  <= step_ms_in;
         total_ms_ff <= total_ms_in;
         retry_ff    <= retry_in;
      end
      if (proc) begin
         cur_ff <= cur_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
      if (proc) begin
         rsp_data_ff.pad             <= '0;
         rsp_data_ff.evaluator_reset <= ev_reset;
         rsp_data_ff.total_time_ms   <= total_ms_in;
         rsp_data_ff.step_time_ms    <= step_ms_in;
         rsp_data_ff.retries_used    <= retry_in;
         rsp_data_ff.current_id      <= cur_id;
         rsp_data_ff.current_index   <= index_in;
         rsp_data_ff.status          <= status_in;
      end
   end

endmodule

[design/tsseq_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tsseq_checker: port-level checks of the timed step sequencer
// Watches the response channel for handshake and content rules.
// -----------------------------------------------------------------------------
module tsseq_checker
   import tsseq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);

   rsp_data_type rsp;
   assign rsp = rsp_data_type'(rsp_tdata);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No response right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // An evaluator reset starts a fresh attempt of a running step
   a_ev_reset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.evaluator_reset |->
         rsp.status == ST_RUNNING && rsp.step_time_ms == '0)
      else $error("evaluator reset without a fresh running step");

   // Current id is a 15-bit id or the no-step marker
   a_id_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp.current_id[CUR_ID_W-1] || rsp.current_id == ID_NONE)
      else $error("malformed current id");

endmodule

bind timed_step_sequencer tsseq_checker u_tsseq_checker (.*);
